>>> rtl/assert_macros.svh
// Assertion macros used by the sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define OVS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define OVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ovs_pkg.sv
// Package with shared constants and types of the ordered value sorter.
`timescale 1ns / 1ps
package ovs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed width of the value fields on the channels
  localparam int VALUE_W = 32;

  // Control handed from the sequencer to every cell
  typedef struct packed {
    logic shift;  // move the held values one cell toward the head
    logic desc;   // 1 keeps the larger value, 0 the smaller one
  } ctl_t;

endpackage

>>> rtl/ovs_if.sv
// Valid/ready channel interfaces for the sorter input and result streams.
`timescale 1ns / 1ps
interface ovs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ovs_pkg::VALUE_W-1:0] value;
  logic                                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ovs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ovs_pkg::VALUE_W-1:0] sorted_value;
  logic                                last_out;
  logic                                overflowed;

  modport source (output valid, output sorted_value, output last_out, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflowed,
                  output ready);
endinterface

>>> rtl/ovs_cell.sv
// One insertion cell: keeps the better of its held value and the arriving one.
`timescale 1ns / 1ps
module ovs_cell #(
  parameter int DATA_WIDTH = ovs_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ovs_pkg::ctl_t         ctl_i,
  // token arriving from the cell toward the head
  input  logic                  tok_vld_i,
  input  logic [DATA_WIDTH-1:0] tok_dat_i,
  // token passed on toward the tail
  output logic                  tok_vld_o,
  output logic [DATA_WIDTH-1:0] tok_dat_o,
  // held value of the neighbor toward the tail, taken on a shift
  input  logic                  nbr_vld_i,
  input  logic [DATA_WIDTH-1:0] nbr_dat_i,
  // held value of this cell
  output logic                  held_vld_o,
  output logic [DATA_WIDTH-1:0] held_dat_o
);
  import ovs_pkg::*;

  logic                  held_vld_r, held_vld_nxt;
  logic [DATA_WIDTH-1:0] held_dat_r, held_dat_nxt;
  logic                  tok_vld_r, tok_vld_nxt;
  logic [DATA_WIDTH-1:0] tok_dat_r, tok_dat_nxt;
  logic                  better;

  // Compare as signed numbers in the selected direction
  assign better = ctl_i.desc ? ($signed(tok_dat_i) > $signed(held_dat_r))
                             : ($signed(tok_dat_i) < $signed(held_dat_r));

  // Keep the better value, pass the other one on; on a shift take the neighbor's held value
  always_comb begin
    held_vld_nxt = held_vld_r;
    held_dat_nxt = held_dat_r;
    tok_vld_nxt  = 1'b0;
    tok_dat_nxt  = tok_dat_r;
    if (ctl_i.shift) begin
      held_vld_nxt = nbr_vld_i;
      held_dat_nxt = nbr_dat_i;
    end else if (tok_vld_i) begin
      if (!held_vld_r) begin
        held_vld_nxt = 1'b1;
        held_dat_nxt = tok_dat_i;
      end else if (better) begin
        held_dat_nxt = tok_dat_i;
        tok_vld_nxt  = 1'b1;
        tok_dat_nxt  = held_dat_r;
      end else begin
        tok_vld_nxt  = 1'b1;
        tok_dat_nxt  = tok_dat_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      tok_vld_r  <= 1'b0;
    end else begin
      held_vld_r <= held_vld_nxt;
      tok_vld_r  <= tok_vld_nxt;
    end
    held_dat_r <= held_dat_nxt;
    tok_dat_r  <= tok_dat_nxt;
  end

  assign tok_vld_o  = tok_vld_r;
  assign tok_dat_o  = tok_dat_r;
  assign held_vld_o = held_vld_r;
  assign held_dat_o = held_dat_r;

endmodule

>>> rtl/ordered_value_sorter_unit.sv
// Top level of the ordered value sorter: insertion cell chain and sequencer.
//
// Usage: values arrive on in_chan (valid/ready), one per transaction; the
// transaction with is_last set closes a block. Up to MAX_ITEMS values are kept;
// further values are dropped and every result of that block has overflowed set.
// The closing value is dropped too when the store is already full.
// Each accepted value enters the head cell of a chain of MAX_ITEMS cells and
// ripples toward the tail one cell per cycle, so values are taken back to back,
// one per cycle, while a block is being collected.
// After the closing transaction a settle phase lets the chain settle over its
// longest ripple path, then the block is sent on out_chan, head cell first, one
// result per cycle while out_chan is ready, with last_out on the final one. Input
// ready is low from the closing transaction until the final result is taken. A
// stalled receiver holds the chain: the head value stays on out_chan until taken.
// cfg_we/cfg_wdata set the sort direction (1 = largest first); write it only
// while no block is in flight. Reset (rst_n low, synchronous) empties the
// chain, clears the count and overflow flag and selects ascending order.
`timescale 1ns / 1ps
module ordered_value_sorter_unit #(
  parameter int MAX_ITEMS  = ovs_pkg::MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = ovs_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ovs_in_if.sink    in_chan,
  ovs_out_if.source out_chan,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import ovs_pkg::*;
`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = $clog2(MAX_ITEMS);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_SETTLE  = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] settle_r, settle_nxt;
  logic          ovf_r, ovf_nxt;
  logic          desc_r;
  logic          in_acc, out_acc, has_room;
  ctl_t          ctl;

  logic                  tok_vld [0:MAX_ITEMS];
  logic [DATA_WIDTH-1:0] tok_dat [0:MAX_ITEMS];
  logic                  held_vld [0:MAX_ITEMS];
  logic [DATA_WIDTH-1:0] held_dat [0:MAX_ITEMS];

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_acc  = out_chan.valid && out_chan.ready;
  assign has_room = count_r < CW'(MAX_ITEMS);

  assign ctl.shift = out_acc;
  assign ctl.desc  = desc_r;

  // Feed kept values into the head cell
  assign tok_vld[0] = in_acc && has_room;
  assign tok_dat[0] = DATA_WIDTH'(in_chan.value);

  // Nothing lies beyond the tail cell
  assign held_vld[MAX_ITEMS] = 1'b0;
  assign held_dat[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ovs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .tok_vld_i  (tok_vld[i]),
      .tok_dat_i  (tok_dat[i]),
      .tok_vld_o  (tok_vld[i+1]),
      .tok_dat_o  (tok_dat[i+1]),
      .nbr_vld_i  (held_vld[i+1]),
      .nbr_dat_i  (held_dat[i+1]),
      .held_vld_o (held_vld[i]),
      .held_dat_o (held_dat[i])
    );
  end

  // Sequence collect, settle and drain phases
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    settle_nxt = settle_r;
    ovf_nxt    = ovf_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (has_room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.is_last) begin
            state_nxt  = ST_SETTLE;
            settle_nxt = '0;
          end
        end
      end
      ST_SETTLE: begin
        settle_nxt = settle_r + SW'(1);
        if (settle_r == SW'(MAX_ITEMS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_COLLECT;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      count_r  <= '0;
      settle_r <= '0;
      ovf_r    <= 1'b0;
      desc_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      settle_r <= settle_nxt;
      ovf_r    <= ovf_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  // Drive the channels
  assign in_chan.ready         = (state_r == ST_COLLECT);
  assign out_chan.valid        = (state_r == ST_DRAIN);
  assign out_chan.sorted_value = VALUE_W'(held_dat[0]);
  assign out_chan.last_out     = (count_r == CW'(1));
  assign out_chan.overflowed   = ovf_r;

  `OVS_ASSERT_ALWAYS(a_head_full, !out_chan.valid || held_vld[0],
    "result offered while the head cell is empty")
  `OVS_ASSERT_ALWAYS(a_tail_quiet, !tok_vld[MAX_ITEMS],
    "value pushed out past the tail cell")
  `OVS_ASSERT_ALWAYS(a_drain_count, !out_chan.valid || (count_r != '0),
    "result offered with no values left")
  `OVS_ASSERT_NEXT(a_close_settle, in_acc && in_chan.is_last, state_r == ST_SETTLE,
    "closing transaction did not start the settle phase")

endmodule

>>> bench/ordered_value_sorter_unit_tb.sv
// Self-checking testbench for the ordered value sorter: block stimulus, sort prediction, checks.
`timescale 1ns / 1ps
module ordered_value_sorter_unit_tb;
  import ovs_pkg::*;

  localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
  localparam int SETTLE_CYC  = 2 * MAX_ITEMS + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t sorted_value;
    logic   last_out;
    logic   overflowed;
  } sorted_result_t;

  // Collect one block, predict its sorted output, compare against the DUT
  class block_sort_predictor;
    value_t         block_values[$];
    sorted_result_t expected_order[$];
    bit             overflow_seen;
    bit             descending;
    int             errors;

    function void set_descending(bit dir);
      descending = dir;
    endfunction

    function int pending();
      return expected_order.size();
    endfunction

    function void note_value(value_t val, bit closes);
      value_t         ranked[$];
      sorted_result_t res;
      int             pos;
      // keep what fits, flag the rest as dropped
      if (block_values.size() < MAX_ITEMS) begin
        block_values.push_back(val);
      end else begin
        overflow_seen = 1'b1;
      end
      if (!closes) begin
        return;
      end
      // insert each kept value at its place in the requested order
      foreach (block_values[i]) begin
        pos = ranked.size();
        for (int j = 0; j < ranked.size(); j++) begin
          if (descending ? (block_values[i] > ranked[j]) : (block_values[i] < ranked[j])) begin
            pos = j;
            break;
          end
        end
        ranked.insert(pos, block_values[i]);
      end
      foreach (ranked[k]) begin
        res.sorted_value = ranked[k];
        res.last_out     = (k == ranked.size() - 1);
        res.overflowed   = overflow_seen;
        expected_order.push_back(res);
      end
      block_values.delete();
      overflow_seen = 1'b0;
    endfunction

    function void check_result(value_t val, logic last_out, logic overflowed);
      sorted_result_t exp;
      if (expected_order.size() == 0) begin
        $error("unexpected result: sorted_value %0d last_out %0b overflowed %0b",
               val, last_out, overflowed);
        errors++;
        return;
      end
      exp = expected_order.pop_front();
      if (val !== exp.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", exp.sorted_value, val);
        errors++;
      end
      if (last_out !== exp.last_out) begin
        $error("last_out: expected %0b, got %0b", exp.last_out, last_out);
        errors++;
      end
      if (overflowed !== exp.overflowed) begin
        $error("overflowed: expected %0b, got %0b", exp.overflowed, overflowed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   cycle_count = 0;

  block_sort_predictor book;

  ovs_in_if  in_chan();
  ovs_out_if out_chan();

  ordered_value_sorter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap before a transaction: mostly none, some short, a few long
  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of corner values, a narrow band for duplicates and full-range values
  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Offer one transaction and hold it until taken; call at a rising edge
  task automatic put_value(input value_t val, input bit closes, input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.value   <= val;
    in_chan.is_last <= closes;
    do @(posedge clk); while (!in_chan.ready);
    book.note_value(val, closes);
  endtask

  task automatic send_fixed(input value_t vals[$]);
    foreach (vals[i]) begin
      put_value(vals[i], i == vals.size() - 1, next_gap());
    end
  endtask

  task automatic send_random_block(input int len);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      put_value(random_value(), i == len - 1, burst ? 0 : next_gap());
    end
  endtask

  // Short blocks, one long block, then short blocks up to the item target
  task automatic run_phase(input int long_len, input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < 12) begin
      len = $urandom_range(1, 8);
      send_random_block(len);
      sent += len;
    end
    send_random_block(long_len);
    sent += long_len;
    while (sent < target) begin
      len = $urandom_range(1, 8);
      send_random_block(len);
      sent += len;
    end
  endtask

  // Drop valid, wait for every expected result, then let the chain settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_direction(input bit dir);
    cfg_we    <= 1'b1;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_descending(dir);
  endtask

  // Result side: check each accepted transaction, stall at random, with a stall-free window and one long hold
  initial begin : result_sink
    int stall_left;
    int results_seen;
    bit long_hold_done;
    int pick;
    out_chan.ready <= 1'b0;
    stall_left     = 0;
    results_seen   = 0;
    long_hold_done = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        book.check_result(out_chan.sorted_value, out_chan.last_out, out_chan.overflowed);
        results_seen++;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (!long_hold_done && results_seen >= 40) begin
        // hold off long enough for the sender to back up behind a full block
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else if ((cycle_count / 600) % 4 == 1) begin
        out_chan.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_chan.ready <= 1'b1;
        end else if (pick < 95) begin
          stall_left     = $urandom_range(0, 2);
          out_chan.ready <= 1'b0;
        end else begin
          stall_left     = $urandom_range(9, 39);
          out_chan.ready <= 1'b0;
        end
      end
    end
  end

  // Stimulus: directed blocks in both directions, then random phases
  initial begin : stimulus
    value_t fixed[$];
    in_chan.valid   <= 1'b0;
    in_chan.value   <= '0;
    in_chan.is_last <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    rst_n           <= 1'b0;
    book = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascending: extremes and alternating bit patterns, single value, duplicates
    write_direction(1'b0);
    fixed = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
              32'sh55555555, 32'shaaaaaaaa};
    send_fixed(fixed);
    fixed = '{32'sd42};
    send_fixed(fixed);
    fixed = '{32'sd5, -32'sd3, 32'sd5, -32'sd3, 32'sd5};
    send_fixed(fixed);
    drain();

    // descending: same extremes, then an already ascending block
    write_direction(1'b1);
    fixed = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
              32'sh55555555, 32'shaaaaaaaa};
    send_fixed(fixed);
    fixed = '{32'sd1, 32'sd2, 32'sd3};
    send_fixed(fixed);
    drain();

    // random: exactly full store, then overflow with the closing value dropped
    write_direction(1'b0);
    run_phase(MAX_ITEMS, 80);
    drain();

    write_direction(1'b1);
    run_phase($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6), 75);
    drain();

    write_direction(1'b0);
    run_phase(16, 30);
    drain();

    if (book.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ovs_pkg.sv
rtl/ovs_if.sv
rtl/ovs_cell.sv
rtl/ordered_value_sorter_unit.sv
bench/ordered_value_sorter_unit_tb.sv
